// ===== rtl/vaus_pkg.sv =====
`default_nettype none

package vaus_pkg;

    // Byte window that holds the lookahead bytes
    localparam int WinDepth = 9;
    localparam int EvalLen  = 8;
    localparam int FillW    = $clog2(WinDepth + 1);

    typedef logic [7:0] t_byte;
    typedef logic [FillW-1:0] t_fill;
    typedef logic [2:0] t_skip;

    // Bytes p..p+7 of one evaluated stream position
    typedef logic [0:EvalLen-1][7:0] t_seq;

    typedef enum logic {
        CODEC_H264 = 1'b0,
        CODEC_H265 = 1'b1
    } t_codec;

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    // Matcher results
    typedef struct packed {
        logic pic_hit;
        logic cut_hit;
    } t_match;

    // Fill levels and skip loads
    localparam t_fill FillFull    = t_fill'(WinDepth);
    localparam t_fill FillPreEval = t_fill'(EvalLen - 1);
    localparam t_fill FillOne     = t_fill'(1);
    localparam t_fill FillZero    = t_fill'(0);
    localparam t_skip SkipH264    = 3'd7;
    localparam t_skip SkipH265    = 3'd3;

    // NAL header decoding constants
    localparam logic [7:0] MaskType264 = 8'h1F;
    localparam logic [7:0] MaskType265 = 8'h7D;
    localparam logic [7:0] MaskFirst   = 8'h80;
    localparam logic [4:0] Nal264Slice = 5'd1;
    localparam logic [4:0] Nal264Idr   = 5'd5;
    localparam logic [4:0] Nal264Sei   = 5'd6;
    localparam logic [4:0] Nal264Sps   = 5'd7;
    localparam logic [4:0] Nal264Pps   = 5'd8;
    localparam logic [4:0] Nal264Sub   = 5'd15;
    localparam logic [4:0] Nal264Ext   = 5'd20;
    localparam logic [7:0] Hdr265SlcMax = 8'h2A;
    localparam logic [7:0] Hdr265Vps    = 8'h40;
    localparam logic [7:0] Hdr265Sps    = 8'h42;
    localparam logic [7:0] Hdr265Pps    = 8'h44;

endpackage

`default_nettype wire

// ===== rtl/video_access_unit_splitter.sv =====
// Push transaction: one byte per clock, no stall while the result slot drains.
// A push into a full nine-byte window shows its result in the cycle after acceptance.
// Drain transaction: the buffered bytes (0 to 9) leave one per cycle while the result slot is free, and
// the input is held off until the final byte is loaded into the result register.
// Synchronous active-low reset empties the window, clears the picture-start
// tracking, selects H.264 rules and invalidates the result register.
`default_nettype none

module video_access_unit_splitter (
    input  var logic i_clk,
    input  var logic i_rst_n,
    // configuration
    input  var logic i_cfg_valid,
    output var logic o_cfg_ready,
    input  var logic i_cfg_codec_mode,
    // input stream
    input  var logic       i_valid,
    output var logic       o_ready,
    input  var logic       i_cmd,
    input  var logic [7:0] i_data_byte,
    // result stream
    output var logic       o_valid,
    input  var logic       i_ready,
    output var logic [7:0] o_out_byte,
    output var logic       o_unit_end,
    output var logic       o_last
);
    import vaus_pkg::*;

    t_codec r_mode;
    t_byte  r_win [0:WinDepth-1];
    t_byte  n_win [0:WinDepth-1];
    t_fill  r_fill, n_fill;
    logic   r_pss, n_pss;
    t_skip  r_skip, n_skip;
    logic   r_drain, n_drain;

    logic   slot_free;
    logic   in_fire;
    logic   push;
    logic   drain;
    logic   full;
    logic   eval_en;
    logic   cut;
    logic   pss_kept;
    t_seq   eval_seq;
    t_match match;

    logic   ld;
    t_byte  ld_byte;
    logic   ld_unit_end;
    logic   ld_last;

    // Configuration is taken at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= CODEC_H264;
        end else if (i_cfg_valid) begin
            r_mode <= t_codec'(i_cfg_codec_mode);
        end
    end

    // Input handshake
    assign o_ready = !r_drain && slot_free;
    assign in_fire = i_valid && o_ready;
    assign push    = in_fire && (t_cmd'(i_cmd) == CMD_PUSH);
    assign drain   = in_fire && (t_cmd'(i_cmd) == CMD_DRAIN);
    assign full    = (r_fill == FillFull);
    assign eval_en = push && (full || (r_fill == FillPreEval));

    // Position under test: window bytes 1..8 when full, else 0..6 plus the new byte
    always_comb begin
        for (int i = 0; i < EvalLen - 1; i++) begin
            eval_seq[i] = full ? r_win[i+1] : r_win[i];
        end
        eval_seq[EvalLen-1] = full ? r_win[WinDepth-1] : i_data_byte;
    end

    vaus_match u_match (
        .i_mode  (r_mode),
        .i_seq   (eval_seq),
        .o_match (match)
    );

    assign cut      = r_pss && (r_skip == 3'd0) && match.cut_hit;
    assign pss_kept = r_pss && !cut;

    // Window, tracking and result loading
    always_comb begin
        n_win       = r_win;
        n_fill      = r_fill;
        n_pss       = r_pss;
        n_skip      = r_skip;
        n_drain     = r_drain;
        ld          = 1'b0;
        ld_byte     = r_win[0];
        ld_unit_end = 1'b0;
        ld_last     = 1'b0;

        if (r_drain) begin
            if (slot_free) begin
                ld          = 1'b1;
                ld_unit_end = (r_fill == FillOne);
                ld_last     = (r_fill == FillOne);
                for (int i = 0; i < WinDepth - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_fill = r_fill - FillOne;
                if (r_fill == FillOne) begin
                    n_drain = 1'b0;
                end
            end
        end else if (push) begin
            if (full) begin
                ld          = 1'b1;
                ld_unit_end = cut;
                ld_last     = 1'b1;
                for (int i = 0; i < WinDepth - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[WinDepth-1] = i_data_byte;
            end else begin
                n_win[r_fill] = i_data_byte;
                n_fill        = r_fill + FillOne;
            end
        end else if (drain) begin
            n_pss  = 1'b0;
            n_skip = 3'd0;
            if (r_fill != FillZero) begin
                n_drain = 1'b1;
            end
        end

        // Picture-start tracking at an evaluated position
        if (eval_en) begin
            if (pss_kept) begin
                n_pss = 1'b1;
                if (r_skip != 3'd0) begin
                    n_skip = r_skip - 3'd1;
                end
            end else if (match.pic_hit) begin
                n_pss  = 1'b1;
                n_skip = (r_mode == CODEC_H264) ? SkipH264 : SkipH265;
            end else begin
                n_pss = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= FillZero;
            r_pss   <= 1'b0;
            r_skip  <= 3'd0;
            r_drain <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_pss   <= n_pss;
            r_skip  <= n_skip;
            r_drain <= n_drain;
        end
    end

    // Window bytes are only read after being written
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    vaus_outreg u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ld),
        .i_byte     (ld_byte),
        .i_unit_end (ld_unit_end),
        .i_last     (ld_last),
        .o_free     (slot_free),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_unit_end (o_unit_end),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/vaus_match.sv =====
`default_nettype none

module vaus_match (
    input  var vaus_pkg::t_codec i_mode,
    input  var vaus_pkg::t_seq   i_seq,
    output var vaus_pkg::t_match o_match
);
    import vaus_pkg::*;

    logic       start_code;
    logic [4:0] t264;
    logic [7:0] h265;
    logic       pic264;
    logic       pic265;
    logic       cut264;
    logic       cut265;

    // 00 00 01 prefix at the head of the position
    assign start_code = (i_seq[0] == 8'h00) && (i_seq[1] == 8'h00) && (i_seq[2] == 8'h01);

    assign t264 = 5'(i_seq[3] & MaskType264);
    assign h265 = i_seq[3] & MaskType265;

    // First-slice picture starts
    assign pic264 = (((t264 == Nal264Idr) || (t264 == Nal264Slice))
                     && ((i_seq[4] & MaskFirst) != 8'h00))
                 || ((t264 == Nal264Ext) && ((i_seq[7] & MaskFirst) != 8'h00));
    assign pic265 = ((h265 <= Hdr265SlcMax) || (5'(i_seq[3] & MaskType264) == Nal264Slice))
                 && ((i_seq[5] & MaskFirst) != 8'h00);

    // Parameter sets, and in H.264 also SEI, open a new unit
    assign cut264 = (t264 == Nal264Sub) || (t264 == Nal264Sps)
                 || (t264 == Nal264Pps) || (t264 == Nal264Sei) || pic264;
    assign cut265 = (h265 == Hdr265Vps) || (h265 == Hdr265Sps)
                 || (h265 == Hdr265Pps) || pic265;

    always_comb begin
        o_match.pic_hit = 1'b0;
        o_match.cut_hit = 1'b0;
        unique case (i_mode)
            CODEC_H264: begin
                o_match.pic_hit = start_code && pic264;
                o_match.cut_hit = start_code && cut264;
            end
            CODEC_H265: begin
                o_match.pic_hit = start_code && pic265;
                o_match.cut_hit = start_code && cut265;
            end
            default: begin
                o_match.pic_hit = 1'b0;
                o_match.cut_hit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/vaus_outreg.sv =====
`default_nettype none

module vaus_outreg (
    input  var logic            i_clk,
    input  var logic            i_rst_n,
    input  var logic            i_load,
    input  var vaus_pkg::t_byte i_byte,
    input  var logic            i_unit_end,
    input  var logic            i_last,
    output var logic            o_free,
    output var logic            o_valid,
    input  var logic            i_ready,
    output var vaus_pkg::t_byte o_out_byte,
    output var logic            o_unit_end,
    output var logic            o_last
);
    import vaus_pkg::*;

    logic  r_valid;
    t_byte r_byte;
    logic  r_unit_end;
    logic  r_last;

    // Slot can take a new result when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_byte     <= i_byte;
            r_unit_end <= i_unit_end;
            r_last     <= i_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_unit_end = r_unit_end;
    assign o_last     = r_last;

endmodule

`default_nettype wire

// ===== rtl/vaus_check.sv =====
`default_nettype none

module vaus_check (
    input var logic       i_clk,
    input var logic       i_rst_n,
    input var logic       o_ready,
    input var logic       o_valid,
    input var logic       i_ready,
    input var logic [7:0] o_out_byte,
    input var logic       o_unit_end,
    input var logic       o_last
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte)
            && $stable(o_unit_end) && $stable(o_last))
        else $error("stalled result changed");

    // A result that is not marked last never ends a unit
    a_unit_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_unit_end)
        else $error("unit end on a non-final drained byte");

    // While a drain is in flight, no new input transaction is taken
    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input accepted during drain");

endmodule

bind video_access_unit_splitter vaus_check u_vaus_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_byte (o_out_byte),
    .o_unit_end (o_unit_end),
    .o_last     (o_last)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

import vaus_pkg::*;

// One byte leaving the splitter, as the output port shows it
typedef struct packed {
    t_byte out_byte;
    logic  unit_end;
    logic  last;
} t_unit_byte;

// Tracks the lookahead window and the cut rules, and holds the bytes still due
class unit_cut_tracker;
    t_codec     codec;
    t_byte      win [WinDepth];
    int unsigned fill;
    bit         pic_seen;
    t_skip      skip_left;
    t_unit_byte expected_bytes [$];
    int unsigned errors;
    int unsigned bytes_checked;
    int unsigned unit_ends_seen;

    function new();
        codec = CODEC_H264;
        errors = 0;
        bytes_checked = 0;
        unit_ends_seen = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        foreach (win[i]) win[i] = 8'h00;
        fill = 0;
        pic_seen = 1'b0;
        skip_left = 3'd0;
    endfunction

    function void set_codec(t_codec m);
        codec = m;
    endfunction

    function int unsigned outstanding();
        return expected_bytes.size();
    endfunction

    // First slice of a new picture behind a start code
    function bit pic_hit(t_seq s);
        t_byte h;
        if (!(s[0] == 8'h00 && s[1] == 8'h00 && s[2] == 8'h01))
            return 1'b0;
        if (codec == CODEC_H264) begin
            h = s[3] & MaskType264;
            return ((h == Nal264Slice || h == Nal264Idr) && (s[4] & MaskFirst) != 0) ||
                   (h == Nal264Ext && (s[7] & MaskFirst) != 0);
        end
        h = s[3] & MaskType265;
        // low five bits equal to one also count as a slice here
        return (h <= Hdr265SlcMax || (s[3] & MaskType264) == 8'h01) &&
               (s[5] & MaskFirst) != 0;
    endfunction

    // Parameter set, SEI or picture start
    function bit cut_hit(t_seq s);
        t_byte h;
        if (!(s[0] == 8'h00 && s[1] == 8'h00 && s[2] == 8'h01))
            return 1'b0;
        if (codec == CODEC_H264) begin
            h = s[3] & MaskType264;
            if (h == Nal264Sei || h == Nal264Sps || h == Nal264Pps || h == Nal264Sub)
                return 1'b1;
        end else begin
            h = s[3] & MaskType265;
            if (h == Hdr265Vps || h == Hdr265Sps || h == Hdr265Pps)
                return 1'b1;
        end
        return pic_hit(s);
    endfunction

    // Evaluate one stream position; returns 1 when a cut falls before it
    function bit eval_position(t_seq s);
        bit cut;
        cut = 1'b0;
        if (pic_seen && skip_left == 0 && cut_hit(s)) begin
            cut = 1'b1;
            pic_seen = 1'b0;
        end
        if (pic_seen) begin
            if (skip_left != 0)
                skip_left--;
        end else if (pic_hit(s)) begin
            pic_seen = 1'b1;
            skip_left = (codec == CODEC_H264) ? SkipH264 : SkipH265;
        end
        return cut;
    endfunction

    // Accepted input transaction: work out the bytes it releases
    function void note_input(t_cmd cmd, t_byte b);
        t_seq       s;
        t_unit_byte r;
        bit         cut;
        if (cmd == CMD_PUSH) begin
            if (fill == WinDepth) begin
                for (int i = 0; i < EvalLen; i++)
                    s[i] = win[i + 1];
                cut = eval_position(s);
                r.out_byte = win[0];
                r.unit_end = cut;
                r.last = 1'b1;
                expected_bytes.push_back(r);
                for (int i = 0; i < WinDepth - 1; i++)
                    win[i] = win[i + 1];
                win[WinDepth - 1] = b;
            end else begin
                win[fill] = b;
                fill++;
                // first position has nothing before it: picture start only
                if (fill == EvalLen) begin
                    for (int i = 0; i < EvalLen; i++)
                        s[i] = win[i];
                    void'(eval_position(s));
                end
            end
        end else begin
            for (int k = 0; k < fill; k++) begin
                r.out_byte = win[k];
                r.unit_end = (k == fill - 1);
                r.last = (k == fill - 1);
                expected_bytes.push_back(r);
            end
            clear_stream();
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 50)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Accepted output transaction against the oldest expected byte
    task check_result(t_byte ob, logic ue, logic lst);
        t_unit_byte want;
        if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected output byte %02h", ob));
            return;
        end
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (ue)
            unit_ends_seen++;
        if (ob !== want.out_byte)
            report($sformatf("out_byte %02h, expected %02h", ob, want.out_byte));
        if (ue !== want.unit_end)
            report($sformatf("unit_end %b on byte %02h, expected %b", ue, ob, want.unit_end));
        if (lst !== want.last)
            report($sformatf("last %b on byte %02h, expected %b", lst, ob, want.last));
    endtask
endclass

module testbench;

    localparam int ClkPeriod     = 10;
    localparam int ResetCycles   = 6;
    localparam int SettleCycles  = 12;
    localparam int HoldOffCycles = 80;
    localparam int PhaseItems    = 64;
    localparam int NumPhases     = 6;
    localparam int CycleLimit    = 200000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_codec_mode = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_cmd = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_ready = 1'b0;
    logic       o_cfg_ready;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_unit_end;
    logic       o_last;

    unit_cut_tracker sb;

    bit          steady = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          cycles = 0;
    int unsigned items_sent = 0;
    int unsigned drains_sent = 0;
    t_codec      codec_now = CODEC_H264;

    // Directed H.264 unit: IDR start, skip distance, then an SPS that cuts
    t_byte au264 [17] = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h88, 8'hAB, 8'hCD, 8'hEF,
                          8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h1F, 8'h80,
                          8'h7F};
    t_byte hdr264 [12] = '{8'h65, 8'h25, 8'h41, 8'h01, 8'h61, 8'h21, 8'h67, 8'h68,
                           8'h06, 8'h0F, 8'h14, 8'h09};
    t_byte hdr265 [12] = '{8'h26, 8'h28, 8'h02, 8'h00, 8'h2A, 8'h2B, 8'h40, 8'h42,
                           8'h44, 8'h41, 8'h4E, 8'h01};
    t_codec phase_codec [NumPhases] = '{CODEC_H265, CODEC_H264, CODEC_H265,
                                        CODEC_H264, CODEC_H265, CODEC_H264};

    video_access_unit_splitter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_codec_mode (i_cfg_codec_mode),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_unit_end       (o_unit_end),
        .o_last           (o_last)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("TIMEOUT after %0d cycles, %0d bytes still due", cycles, sb.outstanding());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            i_ready <= 1'b0;
            hold_left <= HoldOffCycles;
            hold_done <= 1'b1;
        end else begin
            i_ready <= steady || ($urandom_range(99) >= 17);
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_out_byte, o_unit_end, o_last);
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(t_cmd cmd, t_byte b);
        while (!steady && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(cmd, b);
        items_sent++;
        if (cmd == CMD_DRAIN)
            drains_sent++;
    endtask

    // Stop offering input and let every due byte come out
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_codec(t_codec m);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_codec_mode <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_codec(m);
        codec_now = m;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly NAL units with random content; some noise, broken start codes, drains
    task automatic send_random_chunk();
        int unsigned pick;
        int unsigned len;
        t_byte       hdr;
        pick = $urandom_range(99);
        if (pick < 68) begin
            send_item(CMD_PUSH, 8'h00);
            send_item(CMD_PUSH, 8'h00);
            send_item(CMD_PUSH, 8'h01);
            if ($urandom_range(3) == 0)
                hdr = t_byte'($urandom_range(255));
            else if (codec_now == CODEC_H264)
                hdr = hdr264[$urandom_range(11)];
            else
                hdr = hdr265[$urandom_range(11)];
            send_item(CMD_PUSH, hdr);
            len = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(10);
            repeat (len)
                send_item(CMD_PUSH, ($urandom_range(4) == 0) ? 8'h00
                                                              : t_byte'($urandom_range(255)));
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 6))
                send_item(CMD_PUSH, t_byte'($urandom_range(255)));
        end else if (pick < 89) begin
            // start code that goes wrong, or one preceded by an extra zero
            send_item(CMD_PUSH, 8'h00);
            send_item(CMD_PUSH, 8'h00);
            send_item(CMD_PUSH, ($urandom_range(1) == 0) ? 8'h00
                                                         : t_byte'($urandom_range(2, 255)));
        end else begin
            send_item(CMD_DRAIN, t_byte'($urandom_range(255)));
        end
    endtask

    initial begin : stimulus
        int          p;
        int unsigned phase_start;
        bit          paused;
        sb = new();
        paused = 1'b0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty drain, extreme bytes, partial drain, one full H.264 cut
        write_codec(CODEC_H264);
        send_item(CMD_DRAIN, 8'hFF);
        send_item(CMD_PUSH, 8'hFF);
        send_item(CMD_PUSH, 8'h00);
        send_item(CMD_DRAIN, 8'h00);
        foreach (au264[i])
            send_item(CMD_PUSH, au264[i]);
        send_item(CMD_DRAIN, 8'h5A);
        send_item(CMD_DRAIN, 8'hA5);

        // Random phases, codec switched between them while idle
        for (p = 0; p < NumPhases; p++) begin
            write_codec(phase_codec[p]);
            steady <= (p == 1);
            phase_start = items_sent;
            while (items_sent - phase_start < PhaseItems) begin
                send_random_chunk();
                if (p == 2 && !hold_request && items_sent - phase_start >= 20)
                    hold_request <= 1'b1;
                if (p == 3 && !paused && items_sent - phase_start >= 20) begin
                    wait_for_idle();
                    paused = 1'b1;
                end
            end
            if ($urandom_range(1) == 0)
                send_item(CMD_DRAIN, t_byte'($urandom_range(255)));
        end
        send_item(CMD_DRAIN, 8'h00);
        wait_for_idle();

        $display("Ran %0d input transactions (%0d drains) across H.264 and H.265 settings,",
                 items_sent, drains_sent);
        $display("with %0d output bytes checked and %0d access-unit ends among them.",
                 sb.bytes_checked, sb.unit_ends_seen);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
